/* hw/rtl/uatc_pkg.sv */
// ----------------------------------------------------------------------------
// uatc_pkg
// Shared constants, codes and types of the user activity threshold counter.
// ----------------------------------------------------------------------------
package uatc_pkg;

  // Table geometry
  localparam int USER_ENTRIES = 1024;
  localparam int COUNT_BITS   = 16;
  localparam int ADDR_BITS    = $clog2(USER_ENTRIES);
  localparam int CUR_BITS     = $clog2(USER_ENTRIES + 1);

  // Field widths
  localparam int USER_W      = 10;
  localparam int THR_BITS    = 16;
  localparam int ACTION_W    = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 2;

  // Width at which counts and threshold are compared
  localparam int CMP_W = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_RECORD = 2'd0,
    ACT_FETCH  = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REC_A,
    ST_REC_B,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              found;
    logic [USER_W-1:0] user;
    logic              scan_done;
  } result_t;

endpackage

/* hw/rtl/uatc_ram.sv */
// ----------------------------------------------------------------------------
// uatc_ram
// Simple dual-port synchronous RAM: one write port, one read port and
// registered read data.
// ----------------------------------------------------------------------------
module uatc_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/uatc_ctrl.sv */
// ----------------------------------------------------------------------------
// uatc_ctrl
// Sequencer of the counter table: clearing sweep, read-modify-write of the
// record counters, cursor scan for fetch, and the result register.
// ----------------------------------------------------------------------------
module uatc_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  // Item side
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [uatc_pkg::ACTION_W-1:0]      in_action,
  input  logic [uatc_pkg::USER_W-1:0]        in_snd,
  input  logic [uatc_pkg::USER_W-1:0]        in_rcv,
  // Threshold register
  input  logic [uatc_pkg::THR_BITS-1:0]      thr,
  // Result side
  output logic                               res_valid,
  input  logic                               res_ready,
  output uatc_pkg::result_t                  res,
  // Counter RAM
  output logic                               ram_we,
  output logic [uatc_pkg::ADDR_BITS-1:0]     ram_waddr,
  output logic [uatc_pkg::COUNT_BITS-1:0]    ram_wdata,
  output logic [uatc_pkg::ADDR_BITS-1:0]     ram_raddr,
  input  logic [uatc_pkg::COUNT_BITS-1:0]    ram_rdata
);

  import uatc_pkg::*;

  state_t                state_r, state_nxt;
  logic [USER_W-1:0]     snd_r, snd_nxt;
  logic [USER_W-1:0]     rcv_r, rcv_nxt;
  logic [CUR_BITS-1:0]   cursor_r, cursor_nxt;
  logic [ADDR_BITS-1:0]  rd_id_r, rd_id_nxt;
  logic [ADDR_BITS-1:0]  clr_addr_r, clr_addr_nxt;
  logic                  res_valid_r, res_valid_nxt;
  result_t               res_r, res_nxt;

  logic                  slot_free;
  logic [THR_BITS-1:0]   need;
  logic                  hit;
  logic                  last_id;

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
    bump = (c == COUNT_MAX) ? c : c + COUNT_BITS'(1);
  endfunction

  function automatic logic in_table(input logic [USER_W-1:0] id);
    in_table = (32'(id) < 32'(USER_ENTRIES));
  endfunction

  function automatic logic [ADDR_BITS-1:0] to_addr(input logic [USER_W-1:0] id);
    to_addr = ADDR_BITS'(id);
  endfunction

  // Effective threshold and compare against the beat just read
  assign need      = (thr == '0) ? THR_BITS'(1) : thr;
  assign hit       = (CMP_W'(ram_rdata) >= CMP_W'(need));
  assign last_id   = (rd_id_r == ADDR_BITS'(USER_ENTRIES - 1));
  assign slot_free = !res_valid_r || res_ready;

  // State register and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cursor_r    <= '0;
      clr_addr_r  <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      clr_addr_r  <= clr_addr_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snd_r   <= snd_nxt;
    rcv_r   <= rcv_nxt;
    rd_id_r <= rd_id_nxt;
    res_r   <= res_nxt;
  end

  // Next state, memory requests and result load
  always_comb begin
    state_nxt     = state_r;
    snd_nxt       = snd_r;
    rcv_nxt       = rcv_r;
    cursor_nxt    = cursor_r;
    rd_id_nxt     = rd_id_r;
    clr_addr_nxt  = clr_addr_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !res_ready;
    in_ready      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = clr_addr_r;
    ram_wdata     = '0;
    ram_raddr     = rd_id_r;

    unique case (state_r)
      ST_CLEAR: begin
        // Sweep zeros through the whole table
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
        if (clr_addr_r == ADDR_BITS'(USER_ENTRIES - 1)) begin
          clr_addr_nxt = '0;
          state_nxt    = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + ADDR_BITS'(1);
        end
      end

      ST_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = to_addr(in_snd);
        if (in_valid) begin
          unique case (action_t'(in_action))
            ACT_RECORD: begin
              snd_nxt   = in_snd;
              rcv_nxt   = in_rcv;
              state_nxt = ST_REC_A;
            end
            ACT_FETCH: begin
              if (cursor_r == CUR_BITS'(USER_ENTRIES)) begin
                state_nxt = ST_DONE;
              end else begin
                ram_raddr = cursor_r[ADDR_BITS-1:0];
                rd_id_nxt = cursor_r[ADDR_BITS-1:0];
                state_nxt = ST_SCAN;
              end
            end
            ACT_CLEAR: begin
              cursor_nxt   = '0;
              clr_addr_nxt = '0;
              state_nxt    = ST_CLEAR;
            end
            default: begin
              // Unused code: drop the beat
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_REC_A: begin
        // Write back the sender, read the recipient
        ram_we    = in_table(snd_r);
        ram_waddr = to_addr(snd_r);
        ram_wdata = bump(ram_rdata);
        ram_raddr = to_addr(rcv_r);
        state_nxt = (rcv_r == snd_r) ? ST_IDLE : ST_REC_B;
      end

      ST_REC_B: begin
        ram_we    = in_table(rcv_r);
        ram_waddr = to_addr(rcv_r);
        ram_wdata = bump(ram_rdata);
        state_nxt = ST_IDLE;
      end

      ST_SCAN: begin
        if (hit) begin
          if (slot_free) begin
            res_nxt.found     = 1'b1;
            res_nxt.user      = USER_W'(rd_id_r);
            res_nxt.scan_done = 1'b0;
            res_valid_nxt     = 1'b1;
            cursor_nxt        = CUR_BITS'(rd_id_r) + CUR_BITS'(1);
            state_nxt         = ST_IDLE;
          end else begin
            // Hold: re-read the same entry until the result slot frees
            ram_raddr = rd_id_r;
          end
        end else if (last_id) begin
          cursor_nxt = CUR_BITS'(USER_ENTRIES);
          state_nxt  = ST_DONE;
        end else begin
          ram_raddr = rd_id_r + ADDR_BITS'(1);
          rd_id_nxt = rd_id_r + ADDR_BITS'(1);
        end
      end

      ST_DONE: begin
        if (slot_free) begin
          res_nxt.found     = 1'b0;
          res_nxt.user      = '0;
          res_nxt.scan_done = 1'b1;
          res_valid_nxt     = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  // A result is either a hit or the end of the scan, never both
  a_res_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> (res_r.found != res_r.scan_done))
    else $error("result flags found and scan_done disagree");

  // The cursor never runs past the end of the table
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= CUR_BITS'(USER_ENTRIES))
    else $error("scan cursor beyond table");

  // The table is never written while waiting for a beat
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !ram_we)
    else $error("table write while idle");

  // The sweep ends in idle after its last entry
  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && clr_addr_r == ADDR_BITS'(USER_ENTRIES - 1))
      |=> (state_r == ST_IDLE))
    else $error("clearing sweep did not finish");

  // A new result is only loaded into a free slot
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && !res_ready) |=> ($stable(res_r) && res_valid_r))
    else $error("result overwritten while stalled");

endmodule

/* hw/rtl/user_activity_threshold_counter_top.sv */
// ----------------------------------------------------------------------------
// user_activity_threshold_counter_top
// Per-user saturating event counters with threshold reporting in ID order.
// ----------------------------------------------------------------------------
// The counters live in one single-port-pair RAM (one write, one registered
// read per cycle), so every operation is sequenced through that port. After
// reset and after a clear beat the block sweeps zeros through all
// USER_ENTRIES (1024) entries, one per cycle, with in_tready low; register
// writes are taken during the sweep. A record beat reads the sender's count,
// writes it back incremented while reading the recipient's, then writes that
// back; the last step is skipped when both are the same user. A fetch beat
// scans up from the cursor until an entry qualifies or the table ends;
// once the table is exhausted it reports the end without a scan. A waiting
// result does not block record beats, only the end of the next fetch.
module user_activity_threshold_counter_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input beats
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [uatc_pkg::IN_TDATA_W-1:0]    in_tdata,   // sender_user, recipient_user
  input  logic [uatc_pkg::IN_TUSER_W-1:0]    in_tuser,   // action
  // Result beats
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [uatc_pkg::OUT_TDATA_W-1:0]   out_tdata,  // reported_user
  output logic [uatc_pkg::OUT_TUSER_W-1:0]   out_tuser,  // found, scan_done
  // Threshold register
  input  logic                               cfg_wen,
  input  logic [uatc_pkg::THR_BITS-1:0]      cfg_wdata
);

  import uatc_pkg::*;

  logic [THR_BITS-1:0]   thr_r;
  result_t               res;
  logic                  ram_we;
  logic [ADDR_BITS-1:0]  ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [ADDR_BITS-1:0]  ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;

  // Hold the report threshold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_BITS'(1);
    end else if (cfg_wen) begin
      thr_r <= cfg_wdata;
    end
  end

  uatc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (in_tuser[ACTION_W-1:0]),
    .in_snd    (in_tdata[USER_W-1:0]),
    .in_rcv    (in_tdata[2*USER_W-1:USER_W]),
    .thr       (thr_r),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  uatc_ram #(
    .DEPTH (USER_ENTRIES),
    .WIDTH (COUNT_BITS)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Pack the result beat
  assign out_tdata = OUT_TDATA_W'(res.user);
  assign out_tuser = {res.scan_done, res.found};

endmodule

/* verif/user_activity_threshold_counter_top_tb.sv */
// ----------------------------------------------------------------------------
// user_activity_threshold_counter_top_tb
// Self-checking bench for the per-user activity counter with threshold scan.
// ----------------------------------------------------------------------------
// Drives record, fetch, clear and unused beats into the block and keeps its
// own copy of the counter table, scan cursor and threshold. Every fetch
// accepted queues the report it should produce; each result beat is checked
// field by field against the oldest one. Tests cover the directed corner
// cases, a threshold above every count, long receiver back-pressure and
// random traffic under several sender and receiver idle mixes and threshold
// settings.
// ----------------------------------------------------------------------------
module user_activity_threshold_counter_top_tb;
  import uatc_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = USER_ENTRIES + 64;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int HOT_USERS     = 16;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_BEATS   = 50;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // sender_user, recipient_user
  logic [IN_TUSER_W-1:0]  in_tuser;   // action
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // reported_user
  logic [OUT_TUSER_W-1:0] out_tuser;  // found, scan_done
  logic                   cfg_wen;
  logic [THR_BITS-1:0]    cfg_wdata;

  // Shadow of the block state
  logic [COUNT_BITS-1:0]  activity_counts [USER_ENTRIES];
  int                     scan_pos;
  logic [THR_BITS-1:0]    report_thr;
  result_t                pending_reports [$];

  int                     src_idle_pct;
  int                     sink_stall_pct;
  int                     sink_hold;
  int                     mismatch_count;
  int                     cycle_count;
  logic [USER_W-1:0]      hot_ids [HOT_USERS];
  result_t                seen_rpt;
  result_t                want_rpt;

  user_activity_threshold_counter_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run timed out", $time);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Counter table shadow
  // ---------------------------------------------------------------------------
  task automatic clear_counts();
    foreach (activity_counts[i]) activity_counts[i] = '0;
    scan_pos = 0;
  endtask

  task automatic bump_count(input logic [USER_W-1:0] id);
    // Hold a saturated counter at its maximum
    if (id < USER_ENTRIES && activity_counts[id] != COUNT_MAX)
      activity_counts[id] = activity_counts[id] + 1'b1;
  endtask

  // Advance the cursor to the next user at or above the threshold
  function automatic result_t next_report();
    logic [COUNT_BITS-1:0] need;
    result_t               rpt;
    need = (report_thr == '0) ? COUNT_BITS'(1) : COUNT_BITS'(report_thr);
    rpt  = '{found: 1'b0, user: '0, scan_done: 1'b1};
    while (scan_pos < USER_ENTRIES) begin
      scan_pos++;
      if (activity_counts[scan_pos-1] >= need) begin
        rpt = '{found: 1'b1, user: USER_W'(scan_pos-1), scan_done: 1'b0};
        break;
      end
    end
    return rpt;
  endfunction

  task automatic apply_beat(input logic [ACTION_W-1:0] act,
                            input logic [USER_W-1:0] snd, input logic [USER_W-1:0] rcv);
    case (act)
      ACT_RECORD: begin
        bump_count(snd);
        if (rcv != snd) bump_count(rcv);
      end
      ACT_FETCH: pending_reports = {pending_reports, next_report()};
      ACT_CLEAR: clear_counts();
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic [ACTION_W-1:0] act,
                           input logic [USER_W-1:0] snd, input logic [USER_W-1:0] rcv);
    // Idle the sender for a random number of cycles
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {{(IN_TDATA_W-2*USER_W){1'b0}}, rcv, snd};
    do @(posedge clk); while (!in_tready);
    apply_beat(act, snd, rcv);
  endtask

  // Drain all reports, then let any sweep or record finish
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_BITS-1:0] value);
    cfg_wdata <= value;
    cfg_wen   <= 1'b1;
    @(posedge clk);
    report_thr = value;
    cfg_wen   <= 1'b0;
  endtask

  task automatic set_idling(input int src_pct, input int sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  function automatic logic [USER_W-1:0] pick_user();
    if ($urandom_range(99) < 75) return hot_ids[$urandom_range(HOT_USERS-1)];
    return USER_W'($urandom_range(USER_ENTRIES-1));
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------
  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_rpt = '{found: out_tuser[0], user: out_tdata[USER_W-1:0], scan_done: out_tuser[1]};
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual found=%0d user=%0d done=%0d",
                 $time, seen_rpt.found, seen_rpt.user, seen_rpt.scan_done);
        mismatch_count++;
      end else begin
        want_rpt = pending_reports.pop_front();
        check_field("found", want_rpt.found, seen_rpt.found);
        check_field("reported_user", want_rpt.user, seen_rpt.user);
        check_field("scan_done", want_rpt.scan_done, seen_rpt.scan_done);
      end
    end
    // Hold off for a counted stretch, else stall at random
    if (sink_hold > 0) begin
      sink_hold  <= sink_hold - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    set_idling(0, 0);
    // Reset threshold of one: every touched user qualifies
    send_beat(ACT_RECORD, 10'd0, 10'd0);
    send_beat(ACT_RECORD, 10'd1023, 10'd1023);
    send_beat(ACT_RECORD, 10'd5, 10'd7);
    send_beat(ACT_RECORD, 10'd7, 10'd5);
    send_beat(ACT_UNUSED, 10'd1023, 10'd1023);
    send_beat(ACT_RECORD, 10'd3, 10'd3);
    repeat (5) send_beat(ACT_FETCH, 10'd0, 10'd0);
    send_beat(ACT_FETCH, 10'd1023, 10'd1023);
    // Entries below the cursor stay skipped
    send_beat(ACT_RECORD, 10'd2, 10'd2);
    send_beat(ACT_FETCH, 10'd0, 10'd0);
    send_beat(ACT_CLEAR, 10'd1023, 10'd1023);
    send_beat(ACT_FETCH, 10'd0, 10'd0);
    send_beat(ACT_RECORD, 10'd682, 10'd341);
    send_beat(ACT_FETCH, 10'd0, 10'd0);
    // Zero threshold behaves as one
    wait_idle();
    write_threshold(16'd0);
    send_beat(ACT_FETCH, 10'd0, 10'd0);
    send_beat(ACT_FETCH, 10'd0, 10'd0);
    send_beat(ACT_CLEAR, 10'd0, 10'd0);
    wait_idle();
    write_threshold(16'd2);
    send_beat(ACT_RECORD, 10'd10, 10'd11);
    send_beat(ACT_RECORD, 10'd10, 10'd12);
    send_beat(ACT_RECORD, 10'd11, 10'd11);
    repeat (3) send_beat(ACT_FETCH, 10'd0, 10'd0);
    wait_idle();
  endtask

  task automatic test_high_threshold();
    set_idling(0, 0);
    write_threshold(16'hFFFF);
    send_beat(ACT_CLEAR, 10'd0, 10'd0);
    // Keep every counter below a threshold at the top of the count range
    repeat (6) send_beat(ACT_RECORD, 10'd100, 10'd100);
    send_beat(ACT_RECORD, 10'd100, 10'd200);
    send_beat(ACT_FETCH, 10'd0, 10'd0);
    send_beat(ACT_FETCH, 10'd0, 10'd0);
    wait_idle();
  endtask

  task automatic test_backpressure();
    int n;
    set_idling(0, 0);
    write_threshold(16'd1);
    send_beat(ACT_CLEAR, 10'd0, 10'd0);
    // Let the clearing sweep finish before the receiver holds off
    wait_idle();
    foreach (hot_ids[i]) hot_ids[i] = USER_W'($urandom_range(USER_ENTRIES-1));
    // Block the receiver while beats keep coming
    sink_hold <= 400;
    for (n = 0; n < 40; n++) begin
      if (n % 3 == 2) send_beat(ACT_FETCH, 10'd0, 10'd0);
      else send_beat(ACT_RECORD, pick_user(), pick_user());
    end
    wait_idle();
  endtask

  task automatic test_random();
    logic [THR_BITS-1:0] thr_steps [RAND_PHASES] = '{16'd1, 16'd0, 16'd2, 16'd3,
                                                     16'd1, 16'd4, 16'd0, 16'd2};
    int                  phase;
    int                  sent;
    int                  pick;
    logic [USER_W-1:0]   snd;
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase / 2)
        0: set_idling(0, 0);
        1: set_idling(85, 0);
        2: set_idling(0, 85);
        default: set_idling(38, 38);
      endcase
      write_threshold(thr_steps[phase]);
      foreach (hot_ids[i]) hot_ids[i] = USER_W'($urandom_range(USER_ENTRIES-1));
      sent = 0;
      while (sent < PHASE_BEATS) begin
        pick = $urandom_range(99);
        snd  = pick_user();
        if (pick < 60) begin
          // Mostly records between active users, some self-addressed
          send_beat(ACT_RECORD, snd, ($urandom_range(3) == 0) ? snd : pick_user());
          sent++;
        end else if (pick < 88) begin
          send_beat(ACT_FETCH, USER_W'($urandom), USER_W'($urandom));
          sent++;
        end else if (pick < 91) begin
          send_beat(ACT_CLEAR, USER_W'($urandom), USER_W'($urandom));
          sent++;
        end else begin
          send_beat(ACT_UNUSED, USER_W'($urandom), USER_W'($urandom));
        end
      end
      wait_idle();
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_tvalid      <= 1'b0;
    in_tdata       <= '0;
    in_tuser       <= ACT_RECORD;
    out_tready     <= 1'b0;
    cfg_wen        <= 1'b0;
    cfg_wdata      <= '0;
    cycle_count    = 0;
    mismatch_count = 0;
    sink_hold      = 0;
    report_thr     = 16'd1;
    set_idling(0, 0);
    clear_counts();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_high_threshold();
    test_backpressure();
    test_random();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
